@@ hw/rtl/p2pl_pkg.sv @@
`default_nettype none

package p2pl_pkg;

  // Register reset values
  localparam logic [23:0] WINDOW_RESET = 24'd44100;
  localparam logic [15:0] WEIGHT_RESET = 16'd6554;

  // Register index, taken from paddr[2]
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_WEIGHT = 1'b1;

  // One in unsigned Q0.16, as a 17-bit value
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic [23:0] window_samples;
    logic [15:0] ema_weight;
  } cfg_t;

  // Window stage result: a window ended, with its magnitude
  typedef struct packed {
    logic        valid;
    logic [15:0] mag;
  } win_res_t;

  // Average stage result: magnitude and integer part of the new average
  typedef struct packed {
    logic        valid;
    logic [15:0] mag;
    logic [15:0] avg;
  } ema_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/peak_to_peak_level_ema_top.sv @@
// Peak-to-peak level meter with a moving average of the window magnitude.
// Input channel: sample_valid / sample_stall carry one signed 16-bit sample
// per item. Output channel: result_valid / result_stall carry level,
// peak_to_peak and average, one item at the end of each window and nothing
// for the other samples. The APB port sets window_samples (address 0) and
// ema_weight (address 4); write them only while the block is idle.
// Throughput: one sample per cycle while the output is not stalled. The
// pipeline is four registers deep (input, window extremes, average
// multiply-add, result). The input register loads at the accepting edge;
// a window's result then passes the window, average and result registers.
// The one 17x32 multiply-add of the average update sets the stage timing.
// Reset clears the window, the average and all valid flags, and loads the
// register defaults (44100 samples, weight 6554).
// While result_valid is high and result_stall is high the whole pipeline
// holds and sample_stall is raised; the result held stays unchanged.
`default_nettype none

module peak_to_peak_level_ema_top (
  input  wire logic               clk,
  input  wire logic               rst,
  // APB configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // Sample input
  input  wire logic               sample_valid,
  output logic                    sample_stall,
  input  wire logic signed [15:0] sample,
  // Result output
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [15:0]             level,
  output logic [15:0]             peak_to_peak,
  output logic [15:0]             average
);
  import p2pl_pkg::*;

  cfg_t               cfg;
  win_res_t           win_res;
  ema_res_t           ema_res;
  logic               en;
  logic               in_valid;
  logic signed [15:0] in_sample;

  // Advance the pipeline unless a result is waiting and stalled
  assign en           = !result_valid || !result_stall;
  assign sample_stall = !en;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (en) begin
      in_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && sample_valid) begin
      in_sample <= sample;
    end
  end

  p2pl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  p2pl_window u_window (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (in_valid),
    .in_sample      (in_sample),
    .window_samples (cfg.window_samples),
    .res            (win_res)
  );

  p2pl_ema u_ema (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in         (win_res),
    .ema_weight (cfg.ema_weight),
    .res        (ema_res)
  );

  p2pl_level u_level (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in           (ema_res),
    .result_valid (result_valid),
    .level        (level),
    .peak_to_peak (peak_to_peak),
    .average      (average)
  );

endmodule

`default_nettype wire

@@ hw/rtl/p2pl_regs.sv @@
`default_nettype none

module p2pl_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output p2pl_pkg::cfg_t    cfg
);
  import p2pl_pkg::*;

  logic [23:0] window_samples;
  logic [15:0] ema_weight;

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      window_samples <= WINDOW_RESET;
      ema_weight     <= WEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_WINDOW: window_samples <= pwdata[23:0];
        REG_WEIGHT: ema_weight     <= pwdata[15:0];
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[2])
      REG_WINDOW: prdata = {8'd0, window_samples};
      REG_WEIGHT: prdata = {16'd0, ema_weight};
    endcase
  end

  assign pready             = 1'b1;
  assign cfg.window_samples = window_samples;
  assign cfg.ema_weight     = ema_weight;

endmodule

`default_nettype wire

@@ hw/rtl/p2pl_window.sv @@
`default_nettype none

module p2pl_window (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [15:0] in_sample,
  input  wire logic [23:0]        window_samples,
  output p2pl_pkg::win_res_t      res
);
  import p2pl_pkg::*;

  logic [23:0]        window_count;
  logic signed [15:0] window_max;
  logic signed [15:0] window_min;

  logic [23:0]        count_next;
  logic signed [15:0] max_next;
  logic signed [15:0] min_next;
  logic signed [16:0] span;
  logic               window_end;

  // Take the sample into the extremes and test for the window end
  always_comb begin
    max_next   = (in_sample > window_max) ? in_sample : window_max;
    min_next   = (in_sample < window_min) ? in_sample : window_min;
    count_next = window_count + 24'd1;
    window_end = !(count_next < window_samples);
    span       = 17'(max_next) - 17'(min_next);
  end

  // Advance the window state; clear it when a window ends
  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
      window_max   <= '0;
      window_min   <= '0;
      res.valid    <= 1'b0;
    end else if (en) begin
      res.valid <= in_valid && window_end;
      if (in_valid) begin
        if (window_end) begin
          window_count <= '0;
          window_max   <= '0;
          window_min   <= '0;
        end else begin
          window_count <= count_next;
          window_max   <= max_next;
          window_min   <= min_next;
        end
      end
    end
  end

  // Magnitude of the finished window
  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      res.mag <= span[15:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/p2pl_ema.sv @@
`default_nettype none

module p2pl_ema (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  p2pl_pkg::win_res_t in,
  input  wire logic [15:0]   ema_weight,
  output p2pl_pkg::ema_res_t res
);
  import p2pl_pkg::*;

  // Moving average, unsigned Q16.16
  logic [31:0] smoothed_magnitude;

  logic [16:0] keep_weight;
  logic [31:0] prod_new;
  logic [48:0] prod_old;
  logic [48:0] acc;
  logic [31:0] avg_next;

  // A' = (w*M*65536 + (65536-w)*A) / 65536, truncated
  always_comb begin
    keep_weight = ONE_Q16 - 17'(ema_weight);
    prod_new    = 32'(ema_weight) * 32'(in.mag);
    prod_old    = 49'(keep_weight) * 49'(smoothed_magnitude);
    acc         = {1'b0, prod_new, 16'd0} + prod_old;
    avg_next    = acc[47:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_magnitude <= '0;
      res.valid          <= 1'b0;
    end else if (en) begin
      res.valid <= in.valid;
      if (in.valid) begin
        smoothed_magnitude <= avg_next;
      end
    end
  end

  // Hold magnitude and integer average for the level stage
  always_ff @(posedge clk) begin
    if (en && in.valid) begin
      res.mag <= in.mag;
      res.avg <= avg_next[31:16];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/p2pl_level.sv @@
`default_nettype none

module p2pl_level (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  p2pl_pkg::ema_res_t in,
  output logic               result_valid,
  output logic [15:0]        level,
  output logic [15:0]        peak_to_peak,
  output logic [15:0]        average
);
  import p2pl_pkg::*;

  logic [16:0] diff;
  logic [15:0] level_next;

  // Absolute difference of magnitude and average
  always_comb begin
    diff       = {1'b0, in.mag} - {1'b0, in.avg};
    level_next = diff[16] ? (in.avg - in.mag) : diff[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= in.valid;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (en && in.valid) begin
      level        <= level_next;
      peak_to_peak <= in.mag;
      average      <= in.avg;
    end
  end

endmodule

`default_nettype wire
